// File: rtl/core/fts_pkg.sv
package fts_pkg;

    localparam int unsigned MAX_FANS_DEFAULT = 6;
    localparam int unsigned CMD_DEPTH        = 2;

    localparam int unsigned SPEED_W = 21;
    localparam int unsigned COUNT_W = 16;
    localparam int unsigned FAN_W   = 3;
    localparam int unsigned EXP_W   = 3;
    localparam int unsigned CFG_W   = 3;

    localparam logic [SPEED_W-1:0] SPEED_NUMERATOR = 21'd1350000;
    localparam logic [7:0]         COUNT_SAT       = 8'hFF;
    localparam logic [7:0]         RAISE_ABOVE     = 8'd192;
    localparam logic [7:0]         LOWER_BELOW     = 8'd96;
    localparam logic [EXP_W-1:0]   EXP_MAX         = 3'd7;
    localparam logic [EXP_W-1:0]   EXP_MIN         = 3'd0;
    localparam logic [EXP_W-1:0]   EXP_RESET       = 3'd1;
    localparam logic [CFG_W-1:0]   FAN_LIMIT_RESET = 3'd6;

    typedef enum logic
    {
        CFG_FAN_LIMIT   = 1'b0,
        CFG_DIRECT_MODE = 1'b1
    } fts_cfg_idx_t;

    typedef struct packed
    {
        logic [FAN_W-1:0]   fan_number;
        logic [COUNT_W-1:0] tach_count;
    } fts_in_t;

    typedef struct packed
    {
        logic [FAN_W-1:0]   fan_id;
        logic [SPEED_W-1:0] speed_value;
        logic [EXP_W-1:0]   divisor_exponent;
        logic               divisor_changed;
    } fts_out_t;

    typedef struct packed
    {
        logic [FAN_W-1:0]   fan_id;
        logic [COUNT_W-1:0] value;
        logic [EXP_W-1:0]   shift_exp;
        logic [EXP_W-1:0]   report_exp;
        logic               changed;
        logic               direct;
    } fts_cmd_t;

endpackage

// File: rtl/core/fts_queue.sv
module fts_queue #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [WIDTH-1:0] data_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == FULL_CNT);
    assign empty   = (count_reg == '0);
    assign rd_data = data_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            data_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// File: rtl/core/fts_front.sv
module fts_front #(
    parameter int unsigned MAX_FANS = fts_pkg::MAX_FANS_DEFAULT
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    input  fts_pkg::fts_in_t          item,
    input  logic [fts_pkg::CFG_W-1:0] fan_limit,
    input  logic                      direct_mode,
    input  logic                      cmd_full,
    output logic                      cmd_push,
    output fts_pkg::fts_cmd_t         cmd
);

    import fts_pkg::*;

    localparam int unsigned IDX_W = (MAX_FANS > 1) ? $clog2(MAX_FANS) : 1;
    localparam logic [FAN_W:0] FAN_CAP = (FAN_W + 1)'(MAX_FANS);

    logic [EXP_W-1:0] exp_reg [MAX_FANS];
    logic [IDX_W-1:0] idx;
    logic             in_range;
    logic [7:0]       count_sat;
    logic [EXP_W-1:0] exp_old;
    logic [EXP_W-1:0] exp_new;

    assign idx      = item.fan_number[IDX_W-1:0];
    assign in_range = ({1'b0, item.fan_number} < {1'b0, fan_limit})
                   && ({1'b0, item.fan_number} < FAN_CAP);
    assign cmd_push = push && !cmd_full && in_range;
    assign exp_old  = exp_reg[idx];

    always_comb
    begin
        count_sat = (|item.tach_count[COUNT_W-1:8]) ? COUNT_SAT : item.tach_count[7:0];
        exp_new   = exp_old;
        priority if ((count_sat > RAISE_ABOVE) && (exp_old != EXP_MAX))
        begin
            exp_new = exp_old + 1'b1;
        end
        else if ((count_sat < LOWER_BELOW) && (exp_old != EXP_MIN))
        begin
            exp_new = exp_old - 1'b1;
        end
    end

    always_comb
    begin
        cmd.fan_id    = item.fan_number;
        cmd.shift_exp = exp_old;
        cmd.direct    = direct_mode;
        if (direct_mode)
        begin
            cmd.value      = item.tach_count;
            cmd.report_exp = exp_old;
            cmd.changed    = 1'b0;
        end
        else
        begin
            cmd.value      = {{(COUNT_W-8){1'b0}}, count_sat};
            cmd.report_exp = exp_new;
            cmd.changed    = (exp_new != exp_old);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_FANS; i++)
            begin
                exp_reg[i] <= EXP_RESET;
            end
        end
        else if (cmd_push && !direct_mode)
        begin
            exp_reg[idx] <= exp_new;
        end
    end

endmodule

// File: rtl/core/fts_back.sv
module fts_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_empty,
    input  fts_pkg::fts_cmd_t cmd,
    output logic              cmd_pop,
    output logic              empty,
    input  logic              pop,
    output fts_pkg::fts_out_t result
);

    import fts_pkg::*;

    localparam int unsigned DIV_W  = 15;
    localparam int unsigned STEP_W = $clog2(SPEED_W + 1);
    localparam logic [STEP_W-1:0] STEPS = STEP_W'(SPEED_W);

    typedef enum logic [2:0]
    {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_HOLD = 3'b100
    } fts_state_t;

    fts_state_t         state_reg, state_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [SPEED_W-1:0] quo_reg, quo_next;
    logic [DIV_W-1:0]   rem_reg, rem_next;
    logic [DIV_W-1:0]   dvs_reg, dvs_next;
    logic [FAN_W-1:0]   fan_reg, fan_next;
    logic [EXP_W-1:0]   exp_reg, exp_next;
    logic               chg_reg, chg_next;
    logic               out_valid_reg, out_valid_next;
    fts_out_t           out_reg, out_next;

    logic [7:0]         count;
    logic               special;
    logic [DIV_W:0]     trial;
    logic               fits;
    logic               out_free;

    assign count    = cmd.value[7:0];
    assign special  = cmd.direct || (count == 8'd0) || (count == COUNT_SAT);
    assign trial    = {rem_reg, quo_reg[SPEED_W-1]};
    assign fits     = (trial >= {1'b0, dvs_reg});
    assign out_free = !out_valid_reg || pop;
    assign cmd_pop  = (state_reg == ST_IDLE) && !cmd_empty;
    assign empty    = !out_valid_reg;
    assign result   = out_reg;

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        dvs_next       = dvs_reg;
        fan_next       = fan_reg;
        exp_next       = exp_reg;
        chg_next       = chg_reg;
        out_valid_next = out_valid_reg && !pop;
        out_next       = out_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!cmd_empty)
                begin
                    fan_next = cmd.fan_id;
                    exp_next = cmd.report_exp;
                    chg_next = cmd.changed;
                    rem_next = '0;
                    step_next = STEPS;
                    dvs_next = DIV_W'({7'd0, count} << cmd.shift_exp);
                    if (special)
                    begin
                        quo_next   = cmd.direct ? {{(SPEED_W-COUNT_W){1'b0}}, cmd.value}
                                                : '0;
                        state_next = ST_HOLD;
                    end
                    else
                    begin
                        quo_next   = SPEED_NUMERATOR;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                rem_next  = fits ? DIV_W'(trial - {1'b0, dvs_reg}) : trial[DIV_W-1:0];
                quo_next  = {quo_reg[SPEED_W-2:0], fits};
                step_next = step_reg - 1'b1;
                if (step_reg == STEP_W'(1))
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    out_valid_next            = 1'b1;
                    out_next.fan_id           = fan_reg;
                    out_next.speed_value      = quo_reg;
                    out_next.divisor_exponent = exp_reg;
                    out_next.divisor_changed  = chg_reg;
                    state_next                = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
        fan_reg  <= fan_next;
        exp_reg  <= exp_next;
        chg_reg  <= chg_next;
        out_reg  <= out_next;
    end

endmodule

// File: rtl/core/fan_tach_autorange_speed_core.sv
// channel   direction  handshake            word
// item      in         push / full          fts_in_t  (fan_number, tach_count)
// result    out        empty / pop          fts_out_t (fan_id, speed, exponent, changed)
// config    in         cfg_write            cfg_index, cfg_data
//
// Legacy speed goes from item to result in order: it enters the command queue,
// loads the divider, runs 21 restoring-divider steps, then is registered out.
// Direct mode, zero and saturated counts skip the divider.
// Reset is asynchronous; all exponents return to 1, fan_limit to 6, mode to legacy.
// Items enter the two-word command queue while the divider works; full rises
// only when that queue is full behind a busy divider or a held result.
module fan_tach_autorange_speed_core #(
    parameter int unsigned MAX_FANS = fts_pkg::MAX_FANS_DEFAULT
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    output logic                      full,
    input  fts_pkg::fts_in_t          item,
    output logic                      empty,
    input  logic                      pop,
    output fts_pkg::fts_out_t         result,
    input  logic                      cfg_write,
    input  logic                      cfg_index,
    input  logic [fts_pkg::CFG_W-1:0] cfg_data
);

    import fts_pkg::*;

    logic [CFG_W-1:0] fan_limit_reg;
    logic             direct_mode_reg;
    logic             cmd_push;
    logic             cmd_pop;
    logic             cmd_empty;
    fts_cmd_t         cmd_in;
    fts_cmd_t         cmd_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fan_limit_reg   <= FAN_LIMIT_RESET;
            direct_mode_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (fts_cfg_idx_t'(cfg_index))
                CFG_FAN_LIMIT:   fan_limit_reg   <= cfg_data;
                CFG_DIRECT_MODE: direct_mode_reg <= cfg_data[0];
                default:         fan_limit_reg   <= fan_limit_reg;
            endcase
        end
    end

    fts_front #(
        .MAX_FANS (MAX_FANS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .item        (item),
        .fan_limit   (fan_limit_reg),
        .direct_mode (direct_mode_reg),
        .cmd_full    (full),
        .cmd_push    (cmd_push),
        .cmd         (cmd_in)
    );

    fts_queue #(
        .WIDTH ($bits(fts_cmd_t)),
        .DEPTH (CMD_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_push),
        .wr_data (cmd_in),
        .full    (full),
        .rd_en   (cmd_pop),
        .rd_data (cmd_out),
        .empty   (cmd_empty)
    );

    fts_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cmd_empty),
        .cmd       (cmd_out),
        .cmd_pop   (cmd_pop),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule
